// File: sv/qsbs_pkg.sv
// shared constants and types of the quicksort buffer sorter
package qsbs_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int IDX_W     = $clog2(MAX_ITEMS);
   localparam int CNT_W     = IDX_W + 1;
   localparam int DATA_W    = 32;

   localparam logic [DATA_W-1:0] SIGN_FLIP = {1'b1, {(DATA_W-1){1'b0}}};

   // one pending sub-range of the sort
   typedef struct packed {
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } range_type;

   localparam int RANGE_W = $bits(range_type);

endpackage

// File: sv/qsbs_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module qsbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/quicksort_buffer_sorter.sv
// top level: load, in-place quicksort and read-out of a buffered set of values
//
// each request (start high while busy is low) carries one signed 32-bit value;
// it is written into a 64-entry element ram, and values beyond 64 are dropped
// and flag the set as overflowed. a request with req_last set closes the set:
// busy rises and the stored values are sorted in place by quicksort with
// last-element (lomuto) partitioning, pending sub-ranges held in a second ram
// used as a stack. the element ram has one read and one write port with
// registered read data. the sorted values then leave one per cycle on the
// rsp_ ports, each marked by rsp_strobe for exactly one cycle, and the
// receiver cannot hold them off. the last one carries rsp_last_res and every
// one of the set carries rsp_overflow if anything was dropped. busy falls in
// the cycle in which the final result is shown, so the next set may start
// loading at once.
module quicksort_buffer_sorter (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic signed [qsbs_pkg::DATA_W-1:0] req_value,
   input  logic                             req_last,
   output logic                             rsp_strobe,
   output logic signed [qsbs_pkg::DATA_W-1:0] rsp_value_res,
   output logic                             rsp_last_res,
   output logic                             rsp_overflow
);

   import qsbs_pkg::*;

   // sequencer states, one-hot
   typedef enum logic [12:0] {
      ST_IDLE     = 13'h0001,
      ST_INIT     = 13'h0002,
      ST_POP      = 13'h0004,
      ST_POP_WAIT = 13'h0008,
      ST_PIV_WAIT = 13'h0010,
      ST_SCAN     = 13'h0020,
      ST_SWAP_A   = 13'h0040,
      ST_SWAP_B   = 13'h0080,
      ST_FIN_A    = 13'h0100,
      ST_FIN_B    = 13'h0200,
      ST_PUSH_L   = 13'h0400,
      ST_PUSH_R   = 13'h0800,
      ST_EMIT     = 13'h1000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              dropped_ff, dropped_in;
   logic [CNT_W-1:0]  sp_ff, sp_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [DATA_W-1:0] pivot_ff, pivot_in;
   logic [DATA_W-1:0] vj_ff, vj_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic              strobe_ff, strobe_in;
   logic              last_ff, last_in;
   logic              ovf_ff, ovf_in;

   // element ram port
   logic              e_we;
   logic [IDX_W-1:0]  e_waddr;
   logic [DATA_W-1:0] e_wdata;
   logic [IDX_W-1:0]  e_raddr;
   logic [DATA_W-1:0] e_rdata;

   // range stack port
   logic              s_we;
   logic [IDX_W-1:0]  s_waddr;
   range_type         s_wdata;
   logic [IDX_W-1:0]  s_raddr;
   logic [RANGE_W-1:0] s_rdata_raw;
   range_type         s_rdata;

   // partition scan helpers
   logic              less;
   logic [IDX_W-1:0]  i_adv;
   logic [IDX_W-1:0]  j_next;
   logic [CNT_W-1:0]  count_next;

   qsbs_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (e_we),
      .wr_addr (e_waddr),
      .wr_data (e_wdata),
      .rd_addr (e_raddr),
      .rd_data (e_rdata)
   );

   qsbs_ram #(.WIDTH(RANGE_W), .DEPTH(MAX_ITEMS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata_raw)
   );

   assign s_rdata = range_type'(s_rdata_raw);

   // values live in the ram with the sign bit flipped: unsigned order is signed order
   assign less   = (e_rdata < pivot_ff);
   assign j_next = j_ff + 1'b1;
   assign count_next = count_ff + 1'b1;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      sp_in      = sp_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      pivot_in   = pivot_ff;
      vj_in      = vj_ff;
      k_in       = k_ff;
      strobe_in  = 1'b0;
      last_in    = last_ff;
      ovf_in     = ovf_ff;

      e_we    = 1'b0;
      e_waddr = i_ff;
      e_wdata = pivot_ff;
      e_raddr = j_ff;
      s_we    = 1'b0;
      s_waddr = sp_ff[IDX_W-1:0];
      s_wdata = '{lo: lo_ff, hi: hi_ff};
      s_raddr = sp_ff[IDX_W-1:0];
      i_adv   = i_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (count_ff < CNT_W'(MAX_ITEMS)) begin
                  e_we     = 1'b1;
                  e_waddr  = count_ff[IDX_W-1:0];
                  e_wdata  = req_value ^ SIGN_FLIP;
                  count_in = count_next;
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  state_in = ST_INIT;
               end
            end
         end

         ST_INIT: begin
            k_in = '0;
            if (count_ff < CNT_W'(2)) begin
               state_in = ST_EMIT;
            end else begin
               s_we     = 1'b1;
               s_waddr  = '0;
               s_wdata  = '{lo: '0, hi: IDX_W'(count_ff - 1'b1)};
               sp_in    = CNT_W'(1);
               state_in = ST_POP;
            end
         end

         ST_POP: begin
            if (sp_ff == '0) begin
               k_in     = '0;
               state_in = ST_EMIT;
            end else begin
               sp_in    = sp_ff - 1'b1;
               s_raddr  = IDX_W'(sp_ff - 1'b1);
               state_in = ST_POP_WAIT;
            end
         end

         ST_POP_WAIT: begin
            lo_in   = s_rdata.lo;
            hi_in   = s_rdata.hi;
            e_raddr = s_rdata.hi;
            if (s_rdata.lo >= s_rdata.hi) begin
               state_in = ST_POP;
            end else begin
               state_in = ST_PIV_WAIT;
            end
         end

         ST_PIV_WAIT: begin
            pivot_in = e_rdata;
            i_in     = lo_ff;
            j_in     = lo_ff;
            e_raddr  = lo_ff;
            state_in = ST_SCAN;
         end

         ST_SCAN: begin
            if (less && (i_ff != j_ff)) begin
               vj_in    = e_rdata;
               e_raddr  = i_ff;
               state_in = ST_SWAP_A;
            end else begin
               i_adv = less ? i_ff + 1'b1 : i_ff;
               i_in  = i_adv;
               j_in  = j_next;
               if (j_next == hi_ff) begin
                  e_raddr  = i_adv;
                  state_in = ST_FIN_A;
               end else begin
                  e_raddr  = j_next;
                  state_in = ST_SCAN;
               end
            end
         end

         ST_SWAP_A: begin
            // old store[i] goes to slot j
            e_we     = 1'b1;
            e_waddr  = j_ff;
            e_wdata  = e_rdata;
            state_in = ST_SWAP_B;
         end

         ST_SWAP_B: begin
            e_we    = 1'b1;
            e_waddr = i_ff;
            e_wdata = vj_ff;
            i_adv   = i_ff + 1'b1;
            i_in    = i_adv;
            j_in    = j_next;
            if (j_next == hi_ff) begin
               e_raddr  = i_adv;
               state_in = ST_FIN_A;
            end else begin
               e_raddr  = j_next;
               state_in = ST_SCAN;
            end
         end

         ST_FIN_A: begin
            e_we     = 1'b1;
            e_waddr  = hi_ff;
            e_wdata  = e_rdata;
            state_in = ST_FIN_B;
         end

         ST_FIN_B: begin
            // pivot lands at its final place
            e_we     = 1'b1;
            e_waddr  = i_ff;
            e_wdata  = pivot_ff;
            state_in = ST_PUSH_L;
         end

         ST_PUSH_L: begin
            if (({1'b0, i_ff} > ({1'b0, lo_ff} + 1'b1)) && (sp_ff < CNT_W'(MAX_ITEMS))) begin
               s_we    = 1'b1;
               s_waddr = sp_ff[IDX_W-1:0];
               s_wdata = '{lo: lo_ff, hi: i_ff - 1'b1};
               sp_in   = sp_ff + 1'b1;
            end
            state_in = ST_PUSH_R;
         end

         ST_PUSH_R: begin
            if ((({1'b0, i_ff} + 1'b1) < {1'b0, hi_ff}) && (sp_ff < CNT_W'(MAX_ITEMS))) begin
               s_we    = 1'b1;
               s_waddr = sp_ff[IDX_W-1:0];
               s_wdata = '{lo: i_ff + 1'b1, hi: hi_ff};
               sp_in   = sp_ff + 1'b1;
            end
            state_in = ST_POP;
         end

         ST_EMIT: begin
            e_raddr   = k_ff[IDX_W-1:0];
            strobe_in = 1'b1;
            last_in   = ((k_ff + 1'b1) == count_ff);
            ovf_in    = dropped_ff;
            k_in      = k_ff + 1'b1;
            if ((k_ff + 1'b1) == count_ff) begin
               count_in   = '0;
               dropped_in = 1'b0;
               sp_in      = '0;
               state_in   = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         sp_ff      <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         sp_ff      <= sp_in;
         strobe_ff  <= strobe_in;
      end
   end

   // working registers, no reset needed
   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      pivot_ff <= pivot_in;
      vj_ff    <= vj_in;
      k_ff     <= k_in;
      last_ff  <= last_in;
      ovf_ff   <= ovf_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_value_res = $signed(e_rdata ^ SIGN_FLIP);
   assign rsp_last_res  = last_ff;
   assign rsp_overflow  = ovf_ff;

endmodule

// File: tb/quicksort_buffer_sorter_tb.sv
// self-checking testbench of the quicksort buffer sorter
`timescale 1ns / 1ps

module quicksort_buffer_sorter_tb;

   import qsbs_pkg::*;

   typedef logic signed [DATA_W-1:0] word_type;

   localparam word_type WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam word_type WORD_MAX = ~WORD_MIN;
   localparam int    CYCLE_CAP  = 300000;
   localparam int    PLAN_TOTAL = 370;   // directed and random requests together
   localparam int    TAIL       = 20;

   // contents of a set: how its values are chosen
   typedef enum int {
      SHAPE_RANDOM,
      SHAPE_ASCENDING,
      SHAPE_DESCENDING,
      SHAPE_FEW_VALUES,
      SHAPE_EXTREMES
   } set_shape_type;

   // one request waiting to be driven
   typedef struct {
      word_type value;
      logic  last;
      int    gap;     // idle cycles in front of it
      bit    drain;   // hold it back until every sorted value has come out
   } pending_request_type;

   // one sorted value due on the result ports
   typedef struct {
      word_type value;
      logic  last;
      logic  overflow;
   } sorted_result_type;

   logic  clock = 1'b0;
   logic  reset = 1'b1;
   logic  start = 1'b0;
   logic  busy;
   word_type req_value = '0;
   logic  req_last = 1'b0;
   logic  rsp_strobe;
   word_type rsp_value_res;
   logic  rsp_last_res;
   logic  rsp_overflow;

   pending_request_type pending_requests[$];
   sorted_result_type   sorted_due[$];

   // predictor state: the set being collected, kept in ascending order
   word_type collected_set[$];
   bit    collected_dropped = 1'b0;

   int failures        = 0;
   int requests_taken  = 0;
   int sets_closed     = 0;
   int sets_overflowed = 0;
   int largest_set     = 0;
   int results_checked = 0;
   int cycle_count     = 0;
   int gap_left        = 0;
   bit gap_armed       = 1'b0;

   quicksort_buffer_sorter dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_strobe    (rsp_strobe),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_overflow  (rsp_overflow)
   );

   always #5 clock = ~clock;

   // mostly short gaps, now and then a long one; quiet sets run flat out
   function automatic int pick_gap(bit quiet);
      int roll;
      if (quiet) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      else if (roll < 85) return $urandom_range(1, 3);
      else if (roll < 96) return $urandom_range(4, 10);
      else return $urandom_range(20, 60);
   endfunction

   task automatic add_request(word_type value, logic last, bit quiet, bit drain);
      pending_request_type item;
      item.value = value;
      item.last  = last;
      item.gap   = pick_gap(quiet);
      item.drain = drain;
      pending_requests.push_back(item);
   endtask

   // queue a whole set of n requests, the final one marked last
   task automatic add_set(int n, set_shape_type shape, bit quiet, bit drain);
      word_type v;
      word_type run;
      run = $urandom;
      run = run >>> 2;   // keep ramps well clear of wrapping
      for (int k = 0; k < n; k++) begin
         case (shape)
            SHAPE_ASCENDING: begin
               run = run + word_type'($urandom_range(0, 1 << 20));
               v = run;
            end
            SHAPE_DESCENDING: begin
               run = run - word_type'($urandom_range(0, 1 << 20));
               v = run;
            end
            SHAPE_FEW_VALUES: v = word_type'($urandom_range(0, 3)) - 2;
            SHAPE_EXTREMES: begin
               case ($urandom_range(0, 4))
                  0: v = WORD_MIN;
                  1: v = WORD_MAX;
                  2: v = 0;
                  3: v = -1;
                  default: v = 1;
               endcase
            end
            default: v = $urandom;
         endcase
         add_request(v, k == n - 1, quiet, drain && k == 0);
      end
   endtask

   // model of the block for one accepted request: store it in order, or drop it
   // when the store is full; a last request releases the set in ascending order
   task automatic take_request(word_type value, logic last);
      sorted_result_type r;
      int slot;
      if (collected_set.size() < MAX_ITEMS) begin
         slot = collected_set.size();
         for (int k = 0; k < collected_set.size(); k++) begin
            if (collected_set[k] > value) begin
               slot = k;
               break;
            end
         end
         collected_set.insert(slot, value);
      end else begin
         collected_dropped = 1'b1;
      end
      if (last) begin
         foreach (collected_set[k]) begin
            r.value    = collected_set[k];
            r.last     = (k == collected_set.size() - 1);
            r.overflow = collected_dropped;
            sorted_due.push_back(r);
         end
         sets_closed++;
         if (collected_dropped) sets_overflowed++;
         collected_set.delete();
         collected_dropped = 1'b0;
      end
   endtask

   // driver: a request goes at an edge with start high and busy low; while busy
   // holds it off, start and the request fields stay put
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            take_request(req_value, req_last);
            requests_taken++;
         end
         if (start && busy) begin
            // held off, keep presenting the same request
         end else if (pending_requests.size() == 0) begin
            start <= 1'b0;
         end else begin
            if (!gap_armed) begin
               gap_left  = pending_requests[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_requests[0].drain && (sorted_due.size() != 0 || busy)) begin
               // pause until the previous set has fully drained
               start <= 1'b0;
            end else begin
               req_value <= pending_requests[0].value;
               req_last  <= pending_requests[0].last;
               start     <= 1'b1;
               void'(pending_requests.pop_front());
               gap_armed = 1'b0;
            end
         end
      end
   end

   // monitor: every strobed result is checked against the oldest sorted value due
   always @(posedge clock) begin : check_results
      sorted_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (sorted_due.size() == 0) begin
            $error("unexpected result: value_res %0d last_res %b overflow %b",
                   rsp_value_res, rsp_last_res, rsp_overflow);
            failures++;
         end else begin
            want = sorted_due.pop_front();
            results_checked++;
            if (rsp_value_res !== want.value) begin
               $error("value_res: expected %0d, got %0d", want.value, rsp_value_res);
               failures++;
            end
            if (rsp_last_res !== want.last) begin
               $error("last_res: expected %b, got %b", want.last, rsp_last_res);
               failures++;
            end
            if (rsp_overflow !== want.overflow) begin
               $error("overflow: expected %b, got %b", want.overflow, rsp_overflow);
               failures++;
            end
         end
      end
   end

   // watchdog: a hung handshake or a lost result ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_CAP) begin
         $display("quicksort_buffer_sorter: mismatch");
         $finish;
      end
   end

   initial begin : stimulus
      int n;
      int roll;
      set_shape_type shape;

      // directed sets: lone extremes, a pair out of order, mixed signs around
      // zero, duplicates kept, and short descending and ascending runs
      add_request(WORD_MIN, 1'b1, 1'b0, 1'b0);
      add_request(WORD_MAX, 1'b1, 1'b0, 1'b0);
      add_request(WORD_MAX, 1'b0, 1'b1, 1'b0);
      add_request(WORD_MIN, 1'b1, 1'b1, 1'b0);
      add_request(0, 1'b0, 1'b0, 1'b1);
      add_request(-1, 1'b0, 1'b0, 1'b0);
      add_request(1, 1'b0, 1'b0, 1'b0);
      add_request(WORD_MIN, 1'b0, 1'b0, 1'b0);
      add_request(WORD_MAX, 1'b1, 1'b0, 1'b0);
      add_request(7, 1'b0, 1'b1, 1'b0);
      add_request(-7, 1'b0, 1'b1, 1'b0);
      add_request(7, 1'b0, 1'b1, 1'b0);
      add_request(7, 1'b0, 1'b1, 1'b0);
      add_request(-7, 1'b1, 1'b1, 1'b0);
      add_request(3, 1'b0, 1'b0, 1'b0);
      add_request(3, 1'b1, 1'b0, 1'b0);
      add_set(4, SHAPE_DESCENDING, 1'b1, 1'b1);
      add_set(4, SHAPE_ASCENDING, 1'b0, 1'b0);

      // the slow and the overflowing cases: an ordered full store, a set whose
      // last request is itself dropped, and a long reversed one
      add_set(MAX_ITEMS, SHAPE_ASCENDING, 1'b0, 1'b1);
      add_set(MAX_ITEMS + 1, SHAPE_RANDOM, 1'b1, 1'b0);
      add_set(MAX_ITEMS + 6, SHAPE_DESCENDING, 1'b0, 1'b1);

      // random sets, mostly small, now and then full or over capacity
      while (pending_requests.size() < PLAN_TOTAL) begin
         roll = $urandom_range(0, 99);
         if (roll < 80) n = $urandom_range(1, 12);
         else if (roll < 90) n = $urandom_range(13, 40);
         else if (roll < 95) n = MAX_ITEMS;
         else n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
         shape = set_shape_type'($urandom_range(0, 4));
         add_set(n, shape, $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // sampled on the falling edge, clear of the driver and the monitor
      while (pending_requests.size() != 0 || start) @(negedge clock);
      while (sorted_due.size() != 0) @(negedge clock);
      repeat (TAIL) @(negedge clock);

      $display("covered %0d requests in %0d sets, %0d sorted values checked",
               requests_taken, sets_closed, results_checked);
      $display("%0d sets overran the %0d-entry store", sets_overflowed, MAX_ITEMS);
      if (failures == 0 && sorted_due.size() == 0) begin
         $display("quicksort_buffer_sorter: match");
      end else begin
         $display("quicksort_buffer_sorter: mismatch");
      end
      $finish;
   end

endmodule
